// ===== design/bmi_pkg.sv =====
package bmi_pkg;

  localparam int unsigned WORD_COUNT = 8;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned WIDE_BITS  = WORD_COUNT * WORD_BITS;
  localparam int unsigned IDX_W      = $clog2(WORD_COUNT);
  localparam int unsigned CNT_W      = $clog2(WORD_COUNT + 1);
  localparam int unsigned CFG_IDX_W  = 8;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WIDE_BITS-1:0] wide_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHECK = 9'b000000010,
    ST_TOP   = 9'b000000100,
    ST_HU    = 9'b000001000,
    ST_HV    = 9'b000010000,
    ST_SV    = 9'b000100000,
    ST_SC    = 9'b001000000,
    ST_FIX   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_word;
    logic load_last;
    logic init;
    logic halve_u;
    logic halve_v;
    logic sub_val;
    logic sub_coef;
    logic fix_coef;
    logic out_err;
    idx_t out_idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic u_odd;
    logic v_odd;
    logic u_one;
    logic v_one;
    logic check_ok;
    logic diff_zero;
  } status_t;

endpackage

// ===== design/bmi_datapath.sv =====
module bmi_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bmi_pkg::cmd_t                    cmd_i,
  output bmi_pkg::status_t                 status_o,
  input  logic [bmi_pkg::WORD_BITS-1:0]    operand_word_i,
  input  logic                             cfg_we_i,
  input  logic [bmi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bmi_pkg::WORD_BITS-1:0]    cfg_data_i,
  output logic [bmi_pkg::WORD_BITS-1:0]    word_o
);

  bmi_pkg::word_t m_q [bmi_pkg::WORD_COUNT];
  bmi_pkg::wide_t u_q, u_d, v_q, v_d, r_q, r_d, s_q, s_d;
  bmi_pkg::cnt_t  cnt_q, cnt_d;
  logic           borrow_q, borrow_d;
  logic           sel_q, sel_d;   // 1: v side was reduced

  bmi_pkg::wide_t m;
  logic [bmi_pkg::WIDE_BITS:0] d_uv, d_vu, half_sum, coef_diff, fix_sum;
  bmi_pkg::wide_t half_src, half_res, res;

  always_comb begin
    for (int i = 0; i < bmi_pkg::WORD_COUNT; i++) begin
      m[i*bmi_pkg::WORD_BITS +: bmi_pkg::WORD_BITS] = m_q[i];
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bmi_pkg::WORD_COUNT; i++) m_q[i] <= '0;
    end else if (cfg_we_i && (cfg_index_i < bmi_pkg::CFG_IDX_W'(bmi_pkg::WORD_COUNT))) begin
      m_q[cfg_index_i[bmi_pkg::IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // shared halving adder: (c + m*odd) >> 1
  assign half_src = cmd_i.halve_u ? r_q : s_q;
  assign half_sum = {1'b0, half_src} + (half_src[0] ? {1'b0, m} : '0);
  assign half_res = half_sum[bmi_pkg::WIDE_BITS:1];

  assign d_uv = {1'b0, u_q} - {1'b0, v_q};
  assign d_vu = {1'b0, v_q} - {1'b0, u_q};

  assign coef_diff = sel_q ? ({1'b0, s_q} - {1'b0, r_q}) : ({1'b0, r_q} - {1'b0, s_q});
  assign fix_sum   = (sel_q ? {1'b0, s_q} : {1'b0, r_q}) + {1'b0, m};

  always_comb begin
    u_d = u_q; v_d = v_q; r_d = r_q; s_d = s_q;
    cnt_d = cnt_q; borrow_d = borrow_q; sel_d = sel_q;
    if (cmd_i.load_word) begin
      for (int i = 0; i < bmi_pkg::WORD_COUNT; i++) begin
        if (cnt_q < bmi_pkg::CNT_W'(bmi_pkg::WORD_COUNT) && bmi_pkg::CNT_W'(i) == cnt_q) begin
          v_d[i*bmi_pkg::WORD_BITS +: bmi_pkg::WORD_BITS] = operand_word_i;
        end else if (cmd_i.load_last && bmi_pkg::CNT_W'(i) >= cnt_q) begin
          v_d[i*bmi_pkg::WORD_BITS +: bmi_pkg::WORD_BITS] = '0;
        end
      end
      if (cmd_i.load_last) begin
        cnt_d = '0;
      end else if (cnt_q < bmi_pkg::CNT_W'(bmi_pkg::WORD_COUNT)) begin
        cnt_d = cnt_q + bmi_pkg::CNT_W'(1);
      end
    end
    if (cmd_i.init) begin
      u_d = m;
      r_d = '0;
      s_d = bmi_pkg::WIDE_BITS'(1);
    end
    if (cmd_i.halve_u) begin
      u_d = {1'b0, u_q[bmi_pkg::WIDE_BITS-1:1]};
      r_d = half_res;
    end
    if (cmd_i.halve_v) begin
      v_d = {1'b0, v_q[bmi_pkg::WIDE_BITS-1:1]};
      s_d = half_res;
    end
    if (cmd_i.sub_val) begin
      sel_d = d_uv[bmi_pkg::WIDE_BITS];
      if (d_uv[bmi_pkg::WIDE_BITS]) v_d = d_vu[bmi_pkg::WIDE_BITS-1:0];
      else                          u_d = d_uv[bmi_pkg::WIDE_BITS-1:0];
    end
    if (cmd_i.sub_coef) begin
      borrow_d = coef_diff[bmi_pkg::WIDE_BITS];
      if (sel_q) s_d = coef_diff[bmi_pkg::WIDE_BITS-1:0];
      else       r_d = coef_diff[bmi_pkg::WIDE_BITS-1:0];
    end
    if (cmd_i.fix_coef && borrow_q) begin
      if (sel_q) s_d = fix_sum[bmi_pkg::WIDE_BITS-1:0];
      else       r_d = fix_sum[bmi_pkg::WIDE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d; v_q <= v_d; r_q <= r_d; s_q <= s_d;
    borrow_q <= borrow_d; sel_q <= sel_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  assign status_o.u_odd     = u_q[0];
  assign status_o.v_odd     = v_q[0];
  assign status_o.u_one     = (u_q == bmi_pkg::WIDE_BITS'(1));
  assign status_o.v_one     = (v_q == bmi_pkg::WIDE_BITS'(1));
  assign status_o.check_ok  = m[0] && (v_q != '0) && (v_q < m);
  assign status_o.diff_zero = (u_q == v_q);

  assign res    = status_o.u_one ? r_q : s_q;
  assign word_o = cmd_i.out_err ? '0
                : res[cmd_i.out_idx*bmi_pkg::WORD_BITS +: bmi_pkg::WORD_BITS];

endmodule

// ===== design/bmi_controller.sv =====
module bmi_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             operand_last_i,
  input  bmi_pkg::status_t status_i,
  output bmi_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             result_valid_o,
  output logic             inverse_last_o
);

  bmi_pkg::state_e state_q, state_d;
  bmi_pkg::idx_t   idx_q, idx_d;
  logic            err_q, err_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    err_d   = err_q;
    cmd_o   = '0;
    cmd_o.out_idx = idx_q;
    cmd_o.out_err = err_q;
    result_valid_o = 1'b0;
    inverse_last_o = 1'b0;
    case (state_q)
      bmi_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load_word = 1'b1;
          cmd_o.load_last = operand_last_i;
          if (operand_last_i) state_d = bmi_pkg::ST_CHECK;
        end
      end
      bmi_pkg::ST_CHECK: begin
        if (status_i.check_ok) begin
          cmd_o.init = 1'b1;
          err_d   = 1'b0;
          state_d = bmi_pkg::ST_TOP;
        end else begin
          err_d   = 1'b1;
          state_d = bmi_pkg::ST_OUT;
        end
      end
      bmi_pkg::ST_TOP: begin
        if (status_i.u_one || status_i.v_one) state_d = bmi_pkg::ST_OUT;
        else                                  state_d = bmi_pkg::ST_HU;
      end
      bmi_pkg::ST_HU: begin
        if (!status_i.u_odd) cmd_o.halve_u = 1'b1;
        else                 state_d = bmi_pkg::ST_HV;
      end
      bmi_pkg::ST_HV: begin
        if (!status_i.v_odd) cmd_o.halve_v = 1'b1;
        else                 state_d = bmi_pkg::ST_SV;
      end
      bmi_pkg::ST_SV: begin
        if (status_i.diff_zero) begin
          err_d   = 1'b1;
          state_d = bmi_pkg::ST_OUT;
        end else begin
          cmd_o.sub_val = 1'b1;
          state_d = bmi_pkg::ST_SC;
        end
      end
      bmi_pkg::ST_SC: begin
        cmd_o.sub_coef = 1'b1;
        state_d = bmi_pkg::ST_FIX;
      end
      bmi_pkg::ST_FIX: begin
        cmd_o.fix_coef = 1'b1;
        state_d = bmi_pkg::ST_TOP;
      end
      bmi_pkg::ST_OUT: begin
        result_valid_o = 1'b1;
        if (idx_q == bmi_pkg::IDX_W'(bmi_pkg::WORD_COUNT - 1)) begin
          inverse_last_o = 1'b1;
          idx_d   = '0;
          state_d = bmi_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + bmi_pkg::IDX_W'(1);
        end
      end
      default: state_d = bmi_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != bmi_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmi_pkg::ST_IDLE;
      idx_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== design/binary_modular_inverse_core.sv =====
// Modular inverse of a 512-bit operand modulo an odd 512-bit modulus,
// binary extended Euclid.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0..7 writes modulus words, least significant first. Always ready.
//   Other indexes are dropped. Write only while busy_o is low.
// Operand channel: one 64-bit word per transaction, accepted on a clock with
//   start_i high and busy_o low; operand_last_i marks the final word. Words
//   past the eighth are ignored, missing words count as zero.
// After the last word busy_o rises. The block checks the operand, then runs
//   the loop: each outer pass tests u and v for one (loop test), halves u
//   while it is even and v while it is even (odd tests), then subtracts the
//   smaller of u and v from the larger and the matching coefficients, with
//   a correction by the modulus. One 512-bit add/subtract step per cycle.
// Results: eight transactions on consecutive cycles, each marked by a one
//   cycle result_valid_o strobe, inverse_last_o on the eighth. no_inverse_o
//   is set on all eight (with zero words) for a zero operand, an operand not
//   below the modulus, an even modulus or a non-invertible operand.
//   The receiver cannot stall; busy_o drops after the last result.
// Reset clears the modulus, the word count and the controller.
module binary_modular_inverse_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [bmi_pkg::WORD_BITS-1:0]     operand_word_i,
  input  logic                              operand_last_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bmi_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bmi_pkg::WORD_BITS-1:0]     cfg_data_i,
  output logic                              result_valid_o,
  output logic [bmi_pkg::WORD_BITS-1:0]     inverse_word_o,
  output logic                              inverse_last_o,
  output logic                              no_inverse_o
);

  bmi_pkg::cmd_t    cmd;
  bmi_pkg::status_t status;

  assign cfg_ready_o  = 1'b1;
  assign no_inverse_o = cmd.out_err;

  bmi_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .operand_last_i (operand_last_i),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .inverse_last_o (inverse_last_o)
  );

  bmi_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .operand_word_i (operand_word_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .word_o         (inverse_word_o)
  );

endmodule
